### rtl/dts_pkg.sv
package dts_pkg;

  localparam int MAX_DELIM_BYTES = 8;
  localparam int HOLD_BYTES      = MAX_DELIM_BYTES - 1;
  localparam int QUEUE_DEPTH     = 4;

  localparam int CFG_DATA_W  = 64;
  localparam int CFG_INDEX_W = 1;
  localparam int LEN_W       = 4;
  localparam int POS_W       = 3;

  localparam logic [CFG_INDEX_W-1:0] REG_DELIM_BYTES  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_DELIM_LENGTH = 1'b1;

  localparam logic [CFG_DATA_W-1:0] DELIM_BYTES_RESET  = 64'd9;
  localparam logic [LEN_W-1:0]      DELIM_LENGTH_RESET = 4'd1;

  // Work for the back end: release count bytes of the window starting at
  // start, then optionally close the token.
  typedef struct packed {
    logic [MAX_DELIM_BYTES-1:0][7:0] bytes;
    logic [POS_W-1:0]                start;
    logic [LEN_W-1:0]                count;
    logic                            tend;
    logic                            last;
  } cmd_t;

endpackage

### rtl/dts_channels.sv
interface dts_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       line_last;

  modport source (output valid, output data_byte, output line_last, input ready);
  modport sink (input valid, input data_byte, input line_last, output ready);
endinterface

interface dts_out_if;
  logic       valid;
  logic       ready;
  logic       has_byte;
  logic [7:0] out_byte;
  logic       token_end;
  logic       line_end;
  logic       run_last;

  modport source (output valid, output has_byte, output out_byte, output token_end,
                  output line_end, output run_last, input ready);
  modport sink (input valid, input has_byte, input out_byte, input token_end,
                input line_end, input run_last, output ready);
endinterface

### rtl/dts_front.sv
module dts_front (
  input  logic                              clk,
  input  logic                              rst,
  dts_in_if.sink                            in_ch,
  input  logic                              cfg_wr_en,
  input  logic [dts_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [dts_pkg::CFG_DATA_W-1:0]    cfg_data,
  output dts_pkg::cmd_t                     cmd,
  output logic                              cmd_push,
  input  logic                              cmd_full
);

  localparam int NB = dts_pkg::MAX_DELIM_BYTES;

  logic [dts_pkg::CFG_DATA_W-1:0] delim_bytes;
  logic [dts_pkg::LEN_W-1:0]      delim_length;

  logic [7:0]                 hold [dts_pkg::HOLD_BYTES];
  logic [dts_pkg::POS_W-1:0]  held_count;
  logic                       token_has_bytes;

  logic [dts_pkg::POS_W-1:0]  held_count_next;
  logic                       token_has_bytes_next;

  logic [7:0]                 win [NB];
  logic [dts_pkg::LEN_W-1:0]  len;
  logic [dts_pkg::LEN_W-1:0]  c1;
  logic                       full_win;
  logic                       all_eq;
  logic                       match;
  logic [dts_pkg::LEN_W-1:0]  rel_count;
  logic                       accept;

  assign accept      = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !cmd_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      delim_bytes  <= dts_pkg::DELIM_BYTES_RESET;
      delim_length <= dts_pkg::DELIM_LENGTH_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        dts_pkg::REG_DELIM_BYTES:  delim_bytes  <= cfg_data;
        dts_pkg::REG_DELIM_LENGTH: delim_length <= cfg_data[dts_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Window is right-aligned: newest byte at the top index.
  always_comb begin
    logic [dts_pkg::LEN_W-1:0] pidx;
    logic [7:0]                pbyte;
    for (int j = 0; j < NB - 1; j++) win[j] = hold[j];
    win[NB-1] = in_ch.data_byte;

    if (delim_length == '0) len = dts_pkg::LEN_W'(1);
    else if (delim_length > dts_pkg::LEN_W'(NB)) len = dts_pkg::LEN_W'(NB);
    else len = delim_length;

    c1       = {1'b0, held_count} + dts_pkg::LEN_W'(1);
    full_win = (c1 >= len);

    all_eq = 1'b1;
    for (int j = 0; j < NB; j++) begin
      pidx  = dts_pkg::LEN_W'(j) + len - dts_pkg::LEN_W'(NB);
      pbyte = delim_bytes[8*pidx[dts_pkg::POS_W-1:0] +: 8];
      if ((dts_pkg::LEN_W'(j) + len >= dts_pkg::LEN_W'(NB)) && (win[j] != pbyte))
        all_eq = 1'b0;
    end
    match = full_win && all_eq;

    if (in_ch.line_last && !match) rel_count = c1;
    else if (match)                rel_count = c1 - len;
    else if (full_win)             rel_count = c1 + dts_pkg::LEN_W'(1) - len;
    else                           rel_count = '0;

    if (in_ch.line_last || match) begin
      held_count_next      = '0;
      token_has_bytes_next = 1'b0;
    end else begin
      held_count_next      = full_win ? dts_pkg::POS_W'(len - dts_pkg::LEN_W'(1))
                                      : c1[dts_pkg::POS_W-1:0];
      token_has_bytes_next = token_has_bytes || (rel_count != '0);
    end

    for (int j = 0; j < NB; j++) cmd.bytes[j] = win[j];
    cmd.start = dts_pkg::POS_W'(NB - 1) - held_count;
    cmd.count = rel_count;
    cmd.tend  = match || in_ch.line_last;
    cmd.last  = in_ch.line_last;
  end

  assign cmd_push = accept && ((rel_count != '0) || cmd.tend);

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count      <= '0;
      token_has_bytes <= 1'b0;
    end else if (accept) begin
      held_count      <= held_count_next;
      token_has_bytes <= token_has_bytes_next;
    end
  end

  // Shift the newest byte in; held_count says how many are live.
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int j = 0; j < NB - 1; j++) hold[j] <= win[j+1];
    end
  end

endmodule

### rtl/dts_queue.sv
module dts_queue #(
  parameter int Depth = dts_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  dts_pkg::cmd_t push_data,
  output logic          full,
  input  logic          pop,
  output dts_pkg::cmd_t head,
  output logic          empty
);

  localparam int PW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);

  dts_pkg::cmd_t    slots [Depth];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    fill;

  logic do_push;
  logic do_pop;

  assign full    = (fill == CW'(Depth));
  assign empty   = (fill == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PW'(Depth - 1)) ? '0 : wr_ptr + PW'(1);
      if (do_pop)  rd_ptr <= (rd_ptr == PW'(Depth - 1)) ? '0 : rd_ptr + PW'(1);
      if (do_push && !do_pop)      fill <= fill + CW'(1);
      else if (do_pop && !do_push) fill <= fill - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_data;
  end

endmodule

### rtl/dts_back.sv
module dts_back (
  input  logic          clk,
  input  logic          rst,
  input  dts_pkg::cmd_t head,
  input  logic          empty,
  output logic          pop,
  dts_out_if.source     out_ch
);

  logic                      busy;
  dts_pkg::cmd_t             cur;
  logic [dts_pkg::POS_W-1:0] pos;
  logic [dts_pkg::LEN_W-1:0] remain;

  logic final_res;
  logic take;

  assign final_res = (remain == '0) || ((remain == dts_pkg::LEN_W'(1)) && !cur.tend);
  assign take      = out_ch.valid && out_ch.ready;

  assign out_ch.valid     = busy;
  assign out_ch.has_byte  = (remain != '0);
  assign out_ch.out_byte  = (remain != '0) ? cur.bytes[pos] : 8'd0;
  assign out_ch.token_end = (remain == '0);
  assign out_ch.run_last  = final_res;
  assign out_ch.line_end  = final_res && cur.last;

  // Load the next transaction when idle or when the final result leaves.
  assign pop = !empty && (!busy || (take && final_res));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (pop) begin
      busy <= 1'b1;
    end else if (take && final_res) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur    <= head;
      pos    <= head.start;
      remain <= head.count;
    end else if (take && (remain != '0)) begin
      pos    <= pos + dts_pkg::POS_W'(1);
      remain <= remain - dts_pkg::LEN_W'(1);
    end
  end

  a_close_has_tend: assert property (@(posedge clk) disable iff (rst)
    (busy && remain == '0) |-> cur.tend)
    else $error("token close shown for a transaction without one");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (busy && !out_ch.ready) |=> (busy && $stable(pos) && $stable(remain)))
    else $error("result advanced while the receiver stalled");

  a_idle_after_reset: assert property (@(posedge clk)
    rst |=> !busy)
    else $error("back end busy right after reset");

endmodule

### rtl/delimiter_token_splitter_unit.sv
// Splits a line, one byte per input transaction, into tokens at each leftmost
// non-overlapping occurrence of a configured delimiter of 1 to 8 bytes.
// Input channel: data_byte and line_last. Output channel: one result per
// transaction, carrying either one token byte (has_byte) or a token close
// (token_end), with line_end on the final result of a line and run_last on
// the final result caused by one input byte.
// Configuration: cfg_wr_en with cfg_index 0 writes the delimiter bytes (first
// byte in bits 7:0), index 1 writes the length; write only while idle.
// Throughput: one input byte per cycle while the queue is not full. The
// front end classifies a byte in the cycle it is accepted; the back end
// emits one result per cycle while the receiver is ready, and one input
// can release up to 9 results at a line end flush. A 4-entry queue
// between them absorbs such bursts. The first result of a byte is pushed
// into the queue and then loaded into the back end's result register.
// Reset (rst, synchronous) empties the window, the queue and the output, and
// restores a one-byte TAB delimiter. When the receiver stalls, the current
// result holds; input keeps flowing until the queue fills.
module delimiter_token_splitter_unit #(
  parameter int QueueDepth = dts_pkg::QUEUE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst,
  dts_in_if.sink                          in_ch,
  dts_out_if.source                       out_ch,
  input  logic                            cfg_wr_en,
  input  logic [dts_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [dts_pkg::CFG_DATA_W-1:0]  cfg_data
);

  dts_pkg::cmd_t push_cmd;
  dts_pkg::cmd_t head_cmd;
  logic          push;
  logic          full;
  logic          pop;
  logic          empty;

  dts_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (push_cmd),
    .cmd_push  (push),
    .cmd_full  (full)
  );

  dts_queue #(.Depth(QueueDepth)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_cmd),
    .full      (full),
    .pop       (pop),
    .head      (head_cmd),
    .empty     (empty)
  );

  dts_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head_cmd),
    .empty  (empty),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

### test/dts_split_watch.sv
module dts_split_watch (
  input  logic                            clk,
  input  logic                            rst,
  dts_in_if                               in_mon,
  dts_out_if                              out_mon,
  input  logic                            cfg_wr_en,
  input  logic [dts_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [dts_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                              fail_count,
  output int                              results_due
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic       has_byte;
    logic [7:0] out_byte;
    logic       token_end;
    logic       line_end;
    logic       run_last;
  } split_result_t;

  split_result_t                  due_results[$];
  split_result_t                  step_results[$];
  logic [7:0]                     window[0:dts_pkg::MAX_DELIM_BYTES-1];
  int                             window_fill;
  logic                           token_open;
  logic [dts_pkg::CFG_DATA_W-1:0] delim_pattern;
  logic [dts_pkg::LEN_W-1:0]      delim_len;

  function automatic void clear_window();
    for (int i = 0; i < dts_pkg::MAX_DELIM_BYTES; i++) window[i] = 8'h00;
    window_fill = 0;
  endfunction

  // Emit the oldest held byte and shift the window down.
  function automatic void release_front();
    split_result_t r;
    r = '0;
    r.has_byte = 1'b1;
    r.out_byte = window[0];
    step_results = {step_results, r};
    for (int i = 1; i < window_fill; i++) window[i-1] = window[i];
    window_fill--;
    window[window_fill] = 8'h00;
    token_open = 1'b1;
  endfunction

  task automatic split_byte(input logic [7:0] d, input logic last);
    int            span;
    logic          hit;
    split_result_t r;
    span = (delim_len == 0) ? 1 :
           ((delim_len > dts_pkg::MAX_DELIM_BYTES) ? dts_pkg::MAX_DELIM_BYTES
                                                    : int'(delim_len));
    step_results.delete();
    // A shrunk length may leave too many bytes held: drain down to span-1 first.
    while (window_fill + 1 > span) release_front();
    window[window_fill] = d;
    window_fill++;
    if (window_fill == span) begin
      hit = 1'b1;
      for (int k = 0; k < span; k++) begin
        if (window[k] != delim_pattern[8*k +: 8]) hit = 1'b0;
      end
      if (hit) begin
        r = '0;
        r.token_end = 1'b1;
        step_results = {step_results, r};
        clear_window();
        token_open = 1'b0;
      end else begin
        release_front();
      end
    end
    if (last) begin
      while (window_fill > 0) release_front();
      // No empty token after a closing delimiter.
      if (token_open) begin
        r = '0;
        r.token_end = 1'b1;
        step_results = {step_results, r};
      end
      token_open = 1'b0;
      clear_window();
      if (step_results.size() > 0) step_results[step_results.size()-1].line_end = 1'b1;
    end
    if (step_results.size() > 0) step_results[step_results.size()-1].run_last = 1'b1;
    due_results = {due_results, step_results};
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    split_result_t want;
    if (rst) begin
      due_results.delete();
      clear_window();
      fail_count    = 0;
      token_open    = 1'b0;
      delim_pattern = dts_pkg::DELIM_BYTES_RESET;
      delim_len     = dts_pkg::DELIM_LENGTH_RESET;
    end else begin
      if (in_mon.valid && in_mon.ready) split_byte(in_mon.data_byte, in_mon.line_last);
      if (out_mon.valid && out_mon.ready) begin
        if (due_results.size() == 0) begin
          $error("result transaction with none outstanding: has_byte %0h out_byte %0h",
                 out_mon.has_byte, out_mon.out_byte);
          fail_count++;
        end else begin
          want = due_results.pop_front();
          check_field("has_byte", want.has_byte, out_mon.has_byte);
          check_field("out_byte", want.out_byte, out_mon.out_byte);
          check_field("token_end", want.token_end, out_mon.token_end);
          check_field("line_end", want.line_end, out_mon.line_end);
          check_field("run_last", want.run_last, out_mon.run_last);
        end
      end
      // New settings take effect from the next byte.
      if (cfg_wr_en) begin
        if (cfg_index == dts_pkg::REG_DELIM_BYTES) delim_pattern = cfg_data;
        else if (cfg_index == dts_pkg::REG_DELIM_LENGTH)
          delim_len = cfg_data[dts_pkg::LEN_W-1:0];
      end
    end
    results_due = due_results.size();
  end

endmodule

### test/delimiter_token_splitter_unit_test.sv
module delimiter_token_splitter_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  logic                            clk;
  logic                            rst;
  logic                            cfg_wr_en;
  logic [dts_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [dts_pkg::CFG_DATA_W-1:0]  cfg_data;
  int                              fail_count;
  int                              results_due;
  int                              sent_items;
  int                              sink_wait;
  logic                            calm;

  dts_in_if  byte_ch ();
  dts_out_if result_ch ();

  delimiter_token_splitter_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (byte_ch),
    .out_ch    (result_ch),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  dts_split_watch watch (
    .clk         (clk),
    .rst         (rst),
    .in_mon      (byte_ch),
    .out_mon     (result_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .results_due (results_due)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  // Receiver stalls in random bursts unless calm or in reset.
  always @(posedge clk) begin
    if (rst || calm) begin
      result_ch.ready <= 1'b1;
      sink_wait       <= 0;
    end else if (sink_wait != 0) begin
      result_ch.ready <= 1'b0;
      sink_wait       <= sink_wait - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      result_ch.ready <= 1'b0;
      sink_wait       <= $urandom_range(0, 13);
    end else begin
      result_ch.ready <= 1'b1;
    end
  end

  task automatic send_byte(input logic [7:0] d, input logic last);
    if (!calm && $urandom_range(0, 3) == 0) begin
      byte_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    byte_ch.valid     <= 1'b1;
    byte_ch.data_byte <= d;
    byte_ch.line_last <= last;
    do @(posedge clk); while (!byte_ch.ready);
    sent_items++;
  endtask

  // Drop valid, let every result drain, then allow for bytes still in flight.
  task automatic wait_idle();
    byte_ch.valid <= 1'b0;
    do @(posedge clk); while (results_due != 0);
    repeat (16) @(posedge clk);
  endtask

  task automatic set_delimiter(input logic [dts_pkg::CFG_DATA_W-1:0] pat,
                               input logic [dts_pkg::LEN_W-1:0] len);
    cfg_wr_en <= 1'b1;
    cfg_index <= dts_pkg::REG_DELIM_BYTES;
    cfg_data  <= pat;
    @(posedge clk);
    cfg_index <= dts_pkg::REG_DELIM_LENGTH;
    cfg_data  <= dts_pkg::CFG_DATA_W'(len);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Mostly whole delimiters and partial prefixes, with some noise bytes.
  task automatic send_random_line(input logic [dts_pkg::CFG_DATA_W-1:0] pat,
                                  input int span);
    logic [7:0] line_bytes[$];
    int         target;
    int         pick;
    int         cut;
    target = $urandom_range(1, 16);
    while (line_bytes.size() < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        for (int k = 0; k < span; k++) line_bytes = {line_bytes, pat[8*k +: 8]};
      end else if (pick < 60) begin
        cut = $urandom_range(0, span - 1);
        for (int k = 0; k < cut; k++) line_bytes = {line_bytes, pat[8*k +: 8]};
      end else if (pick < 85) begin
        line_bytes = {line_bytes, pat[8*$urandom_range(0, span - 1) +: 8]};
      end else begin
        line_bytes = {line_bytes, 8'($urandom_range(0, 255))};
      end
    end
    foreach (line_bytes[i]) send_byte(line_bytes[i], i == line_bytes.size() - 1);
  endtask

  initial begin : stimulus
    logic [dts_pkg::CFG_DATA_W-1:0] pat;
    logic [dts_pkg::LEN_W-1:0]      len;
    logic [7:0]                     b0;
    logic [7:0]                     b1;
    int                             span;
    int                             pick;
    rst               <= 1'b1;
    calm              <= 1'b0;
    sent_items         = 0;
    byte_ch.valid     <= 1'b0;
    byte_ch.data_byte <= 8'h00;
    byte_ch.line_last <= 1'b0;
    cfg_wr_en         <= 1'b0;
    cfg_index         <= dts_pkg::REG_DELIM_BYTES;
    cfg_data          <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Reset delimiter is a single TAB.
    send_byte(8'h09, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h09, 1'b0);
    send_byte(8'hFF, 1'b1);
    wait_idle();
    set_delimiter('1, 4'd8);
    repeat (7) send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    // Zero length behaves as one byte.
    wait_idle();
    set_delimiter('0, 4'd0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h41, 1'b1);
    // Oversized length clamps to eight.
    wait_idle();
    set_delimiter('0, 4'd15);
    send_byte(8'h00, 1'b1);
    // Shrink the length while three bytes are held.
    wait_idle();
    set_delimiter(64'h6463_6261, 4'd4);
    send_byte(8'h61, 1'b0);
    send_byte(8'h62, 1'b0);
    send_byte(8'h63, 1'b0);
    wait_idle();
    set_delimiter(64'h6463_6261, 4'd1);
    send_byte(8'h64, 1'b1);
    // Change the delimiter bytes with one byte held.
    wait_idle();
    set_delimiter(64'h6261, 4'd2);
    send_byte(8'h61, 1'b0);
    wait_idle();
    set_delimiter(64'h6361, 4'd2);
    send_byte(8'h63, 1'b1);

    while (sent_items < 265) begin
      calm <= (sent_items > 225) || ($urandom_range(0, 4) == 0);
      pick = $urandom_range(0, 9);
      case (pick)
        0:       len = 4'd0;
        1:       len = 4'($urandom_range(9, 15));
        2:       len = 4'd1;
        3:       len = 4'd8;
        default: len = 4'($urandom_range(1, 8));
      endcase
      b0 = 8'($urandom_range(0, 255));
      b1 = 8'($urandom_range(0, 255));
      case ($urandom_range(0, 3))
        0: pat = {8{b0}};
        1: pat = {$urandom, $urandom};
        2: begin
          for (int k = 0; k < dts_pkg::MAX_DELIM_BYTES; k++)
            pat[8*k +: 8] = {8{1'($urandom)}};
        end
        default: pat = {4{b1, b0}};
      endcase
      span = (len == 0) ? 1 :
             ((len > dts_pkg::MAX_DELIM_BYTES) ? dts_pkg::MAX_DELIM_BYTES : int'(len));
      wait_idle();
      set_delimiter(pat, len);
      repeat ($urandom_range(2, 5)) send_random_line(pat, span);
    end

    wait_idle();
    if (fail_count == 0 && results_due == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
